FILE: rtl/wtcs_pkg.sv
package wtcs_pkg;

  localparam int SCREEN_HEIGHT = 1024;
  localparam int TEXTURE_COUNT = 4;
  localparam int HALF_SCREEN   = SCREEN_HEIGHT / 2;

  localparam int COL_W   = 11;
  localparam int ROW_W   = 10;
  localparam int TEXC_W  = 12;
  localparam int IDX_W   = 2;
  localparam int FRAC_W  = 16;
  localparam int LH_W    = 16;
  localparam int WIDTH_W = 13;
  localparam int LG_W    = 4;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_LG    = 12;

  // quotient bits of 2^(16+lg) / slice height
  localparam int DIV_BITS = FRAC_W + MAX_LG + 1;
  localparam int CNT_W    = $clog2(DIV_BITS);
  localparam int POS_W    = 48;
  localparam int BASE_W   = 18;

  localparam int TEX_REGS  = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH_0       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT_LOG2_0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END               = 4'd8;

  localparam logic MODE_SETUP   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [COL_W-1:0]  column;
    logic [IDX_W-1:0]  tex_index;
    logic [FRAC_W-1:0] wall_x;
    logic              side;
    logic              dir_x_positive;
    logic              dir_y_negative;
    logic [LH_W-1:0]   slice_height;
    logic [ROW_W-1:0]  row_top;
    logic [ROW_W-1:0]  row_bottom;
  } wtcs_in_t;

  typedef struct packed {
    logic [COL_W-1:0]  out_column;
    logic [ROW_W-1:0]  row;
    logic [TEXC_W-1:0] tex_x;
    logic [TEXC_W-1:0] tex_y;
    logic [IDX_W-1:0]  out_tex_index;
    logic              last;
  } wtcs_out_t;

endpackage

FILE: rtl/wall_texture_column_stepper_top.sv
// Texel address generator for one raycast wall column.
// Input channel (in_valid / in_stall / in_data): a set-up beat (mode 0) loads
// a column; each advance beat (mode 1) yields one texel address for the next
// screen row, with last set on the final row. Advance beats with no active
// column yield nothing. A set-up beat never yields a result.
// Result channel (out_valid / out_stall / out_data): one output register.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): texture
// widths at indexes 0..3, height log2 at 4..7; cfg_ready is always high and
// other indexes are ignored. Write only while the block is idle.
// Timing: an advance result appears the cycle after its beat is taken, and
// advances run one per cycle while the output is not stalled. A set-up beat
// keeps in_stall high while the shared multiplier forms the texel column, a
// restoring divider (one quotient bit per cycle) forms the row step and the
// multiplier forms the start position. A stalled result holds, and in_stall
// stays high while it does.
// Reset (rst_n low, synchronous) clears the column, drops any pending
// result and restores widths to 64 and height log2 to 6.
module wall_texture_column_stepper_top (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  wtcs_pkg::wtcs_in_t                       in_data,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output wtcs_pkg::wtcs_out_t                      out_data,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [wtcs_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [wtcs_pkg::CFG_DAT_W-1:0]           cfg_data
);
  import wtcs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_TX   = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_POS  = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      active_r, active_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [WIDTH_W-1:0]        tex_width_r [TEX_REGS];
  logic [LG_W-1:0]           tex_lg_r [TEX_REGS];

  logic [ROW_W-1:0]          cur_row_r, cur_row_nxt;
  logic [ROW_W-1:0]          end_row_r, end_row_nxt;
  logic [TEXC_W-1:0]         held_tex_x_r, held_tex_x_nxt;
  logic [COL_W-1:0]          held_column_r, held_column_nxt;
  logic [IDX_W-1:0]          held_texture_r, held_texture_nxt;
  logic [LG_W-1:0]           held_lg_r, held_lg_nxt;
  logic [TEXC_W-1:0]         held_mask_r, held_mask_nxt;
  logic [DIV_BITS-1:0]       step_r, step_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic [FRAC_W-1:0]         wx_r, wx_nxt;
  logic [WIDTH_W-1:0]        w_r, w_nxt;
  logic                      mirror_r, mirror_nxt;
  logic [LH_W-1:0]           lh_r, lh_nxt;
  logic signed [BASE_W-1:0]  base_r, base_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [LH_W-1:0]           rem_r, rem_nxt;
  wtcs_out_t                 out_r, out_nxt;

  logic                      in_accept;
  logic [IDX_W-1:0]          idx_c;
  logic [WIDTH_W-1:0]        w_raw, w_c;
  logic [LG_W-1:0]           lg_raw, lg_c;
  logic [LH_W-1:0]           lh_c;
  logic [ROW_W-1:0]          de_c;
  logic signed [BASE_W-1:0]  base_c;

  logic signed [BASE_W-1:0]      mul_a;
  logic signed [DIV_BITS:0]      mul_b;
  logic signed [POS_W-1:0]       prod;
  logic [WIDTH_W-1:0]            tx_mirror;
  logic                          div_bit;
  logic [LH_W:0]                 trial, diff;
  logic                          ge;
  logic                          is_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // operand clamps for a set-up beat
  always_comb begin
    idx_c  = (3'(in_data.tex_index) >= 3'(TEXTURE_COUNT)) ?
             IDX_W'(TEXTURE_COUNT - 1) : in_data.tex_index;
    w_raw  = tex_width_r[idx_c];
    lg_raw = tex_lg_r[idx_c];
    if (w_raw == '0) begin
      w_c = WIDTH_W'(1);
    end else if (w_raw > WIDTH_W'(MAX_WIDTH)) begin
      w_c = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_c = w_raw;
    end
    lg_c   = (lg_raw > LG_W'(MAX_LG)) ? LG_W'(MAX_LG) : lg_raw;
    lh_c   = (in_data.slice_height == '0) ? LH_W'(1) : in_data.slice_height;
    de_c   = (11'(in_data.row_bottom) > 11'(SCREEN_HEIGHT - 1)) ?
             ROW_W'(SCREEN_HEIGHT - 1) : in_data.row_bottom;
    base_c = $signed(BASE_W'(in_data.row_top)) + $signed(BASE_W'(lh_c[LH_W-1:1]))
             - $signed(BASE_W'(HALF_SCREEN));
  end

  // shared multiplier: texel column first, then start position
  assign mul_a = (state_r == ST_TX) ? $signed(BASE_W'(wx_r)) : base_r;
  assign mul_b = (state_r == ST_TX) ? $signed((DIV_BITS+1)'(w_r))
                                    : $signed({1'b0, step_r});
  assign prod  = mul_a * mul_b;
  assign tx_mirror = w_r - {1'b0, prod[FRAC_W+TEXC_W-1:FRAC_W]} - WIDTH_W'(1);

  // divider step; dividend is a single one bit at position 16 + lg
  assign div_bit = (cnt_r == CNT_W'(FRAC_W) + CNT_W'(held_lg_r));
  assign trial   = {rem_r, div_bit};
  assign ge      = (trial >= {1'b0, lh_r});
  assign diff    = trial - {1'b0, lh_r};

  assign is_last = (cur_row_r == end_row_r);

  always_comb begin
    state_nxt        = state_r;
    active_nxt       = active_r;
    out_valid_nxt    = out_valid_r && out_stall;
    cur_row_nxt      = cur_row_r;
    end_row_nxt      = end_row_r;
    held_tex_x_nxt   = held_tex_x_r;
    held_column_nxt  = held_column_r;
    held_texture_nxt = held_texture_r;
    held_lg_nxt      = held_lg_r;
    held_mask_nxt    = held_mask_r;
    step_nxt         = step_r;
    pos_nxt          = pos_r;
    wx_nxt           = wx_r;
    w_nxt            = w_r;
    mirror_nxt       = mirror_r;
    lh_nxt           = lh_r;
    base_nxt         = base_r;
    cnt_nxt          = cnt_r;
    rem_nxt          = rem_r;
    out_nxt          = out_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept && in_data.mode == MODE_SETUP) begin
          wx_nxt           = in_data.wall_x;
          w_nxt            = w_c;
          mirror_nxt       = (!in_data.side && in_data.dir_x_positive) ||
                             (in_data.side && in_data.dir_y_negative);
          lh_nxt           = lh_c;
          base_nxt         = base_c;
          held_lg_nxt      = lg_c;
          held_mask_nxt    = TEXC_W'((13'd1 << lg_c) - 13'd1);
          held_column_nxt  = in_data.column;
          held_texture_nxt = idx_c;
          cur_row_nxt      = in_data.row_top;
          end_row_nxt      = de_c;
          active_nxt       = (in_data.row_top <= de_c);
          cnt_nxt          = CNT_W'(DIV_BITS - 1);
          rem_nxt          = '0;
          state_nxt        = ST_TX;
        end else if (in_accept && in_data.mode == MODE_ADVANCE && active_r) begin
          out_nxt.out_column    = held_column_r;
          out_nxt.row           = cur_row_r;
          out_nxt.tex_x         = held_tex_x_r;
          out_nxt.tex_y         = pos_r[FRAC_W+TEXC_W-1:FRAC_W] & held_mask_r;
          out_nxt.out_tex_index = held_texture_r;
          out_nxt.last          = is_last;
          out_valid_nxt         = 1'b1;
          pos_nxt               = pos_r + POS_W'(step_r);
          cur_row_nxt           = cur_row_r + ROW_W'(1);
          if (is_last) begin
            active_nxt = 1'b0;
          end
        end
      end
      ST_TX: begin
        held_tex_x_nxt = mirror_r ? tx_mirror[TEXC_W-1:0]
                                  : prod[FRAC_W+TEXC_W-1:FRAC_W];
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt  = ge ? diff[LH_W-1:0] : trial[LH_W-1:0];
        step_nxt = {step_r[DIV_BITS-2:0], ge};
        if (cnt_r == '0) begin
          state_nxt = ST_POS;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_POS: begin
        pos_nxt   = prod;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TEX_REGS; i++) begin
        tex_width_r[i] <= WIDTH_W'(64);
        tex_lg_r[i]    <= LG_W'(6);
      end
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < REG_TEX_HEIGHT_LOG2_0) begin
          tex_width_r[2'(cfg_index - REG_TEX_WIDTH_0)] <= cfg_data;
        end else if (cfg_index < REG_END) begin
          tex_lg_r[2'(cfg_index - REG_TEX_HEIGHT_LOG2_0)] <= cfg_data[LG_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row_r      <= cur_row_nxt;
    end_row_r      <= end_row_nxt;
    held_tex_x_r   <= held_tex_x_nxt;
    held_column_r  <= held_column_nxt;
    held_texture_r <= held_texture_nxt;
    held_lg_r      <= held_lg_nxt;
    held_mask_r    <= held_mask_nxt;
    step_r         <= step_nxt;
    pos_r          <= pos_nxt;
    wx_r           <= wx_nxt;
    w_r            <= w_nxt;
    mirror_r       <= mirror_nxt;
    lh_r           <= lh_nxt;
    base_r         <= base_nxt;
    cnt_r          <= cnt_nxt;
    rem_r          <= rem_nxt;
    out_r          <= out_nxt;
  end

endmodule
